>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition never true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

>>> rtl/ntt_pkg.sv
// ----------------------------------------------------------------------------
// ntt_pkg
// Constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ntt_pkg;

  localparam int MAX_DEGREE = 4096;
  localparam int TW_DEPTH   = MAX_DEGREE / 2;
  localparam int VALUE_BITS = 62;
  localparam int IDX_BITS   = 12;
  localparam int LOG_BITS   = 4;
  localparam int STAGE_BITS = 4;
  localparam int COEF_AW    = $clog2(MAX_DEGREE);
  localparam int TW_AW      = $clog2(TW_DEPTH);
  localparam int MAX_LOG    = $clog2(MAX_DEGREE);
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  localparam logic [VALUE_BITS-1:0] MOD_RESET = VALUE_BITS'(12289);
  localparam logic [LOG_BITS-1:0]   LOG_RESET = LOG_BITS'(12);

  // register indexes on the config port
  localparam logic [1:0] REG_MODULUS    = 2'd0;
  localparam logic [1:0] REG_LOG_DEGREE = 2'd1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_VALUE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    ACT_LOAD_COEF = 2'd0,
    ACT_LOAD_TW   = 2'd1,
    ACT_RUN       = 2'd2,
    ACT_READ      = 2'd3
  } action_t;

  typedef enum logic {
    MM_REDUCE = 1'b0,
    MM_MUL    = 1'b1
  } mm_op_t;

  typedef enum logic [1:0] {
    OPD_U = 2'd0,
    OPD_V = 2'd1,
    OPD_W = 2'd2
  } opd_t;

  typedef enum logic [1:0] {
    WSEL_VALUE = 2'd0,
    WSEL_SUM   = 2'd1,
    WSEL_DIFF  = 2'd2
  } wsel_t;

  typedef struct packed {
    logic               coef_we;
    logic               coef_re;
    logic [COEF_AW-1:0] coef_addr;
    wsel_t              coef_wsel;
    logic               tw_we;
    logic               tw_re;
    logic [TW_AW-1:0]   tw_addr;
    logic               cap_u;
    logic               cap_v;
    logic               cap_w;
    logic               mm_start;
    mm_op_t             mm_op;
    opd_t               mm_opd;
  } dp_cmd_t;

  typedef struct packed {
    logic                val_ge_q;
    logic                mm_done;
    logic [LOG_BITS-1:0] log_degree;
  } dp_stat_t;

endpackage

>>> rtl/ntt_dp.sv
// ----------------------------------------------------------------------------
// ntt_dp
// Datapath: config registers, coefficient and twiddle stores, operand
// registers, bit-serial modular reduce/multiply unit, butterfly add/sub.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntt_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [ntt_pkg::VALUE_BITS-1:0]   cfg_data,
  input  logic [ntt_pkg::VALUE_BITS-1:0]   value,
  input  ntt_pkg::dp_cmd_t                 cmd,
  output ntt_pkg::dp_stat_t                stat,
  output logic [ntt_pkg::VALUE_BITS-1:0]   coef_rdata
);
  import ntt_pkg::*;

  logic [VALUE_BITS-1:0] modulus;
  logic [LOG_BITS-1:0]   log_degree;

  logic [VALUE_BITS-1:0] coef_mem [MAX_DEGREE];
  logic [VALUE_BITS-1:0] tw_mem [TW_DEPTH];
  logic [VALUE_BITS-1:0] tw_rdata;
  logic [VALUE_BITS-1:0] coef_wdata;

  logic [VALUE_BITS-1:0] u, v, w, t;

  logic                  mm_busy;
  logic                  mm_done;
  logic                  mm_phase;
  mm_op_t                mm_op;
  opd_t                  mm_opd;
  logic [CNT_BITS-1:0]   mm_cnt;
  logic [VALUE_BITS-1:0] acc;

  logic [VALUE_BITS-1:0] start_x, red_src;
  logic [VALUE_BITS:0]   q_ext, red_r, dbl_r, add_r;
  logic [VALUE_BITS-1:0] red_n, dbl_n, add_n, step_n;
  logic                  mm_last, mm_fin;
  logic [VALUE_BITS:0]   sum_r, diff_r;
  logic [VALUE_BITS-1:0] sum_n, diff_n;

  assign q_ext = {1'b0, modulus};

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= MOD_RESET;
      log_degree <= LOG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS: begin
          if (cfg_data >= VALUE_BITS'(2)) modulus <= cfg_data;
        end
        REG_LOG_DEGREE: log_degree <= cfg_data[LOG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // butterfly outputs, u and t already below q
  assign sum_r  = {1'b0, u} + {1'b0, t};
  assign sum_n  = (sum_r >= q_ext) ? VALUE_BITS'(sum_r - q_ext) : sum_r[VALUE_BITS-1:0];
  assign diff_r = {1'b0, u} + q_ext - {1'b0, t};
  assign diff_n = (u >= t) ? VALUE_BITS'(u - t) : diff_r[VALUE_BITS-1:0];

  always_comb begin
    case (cmd.coef_wsel)
      WSEL_SUM:  coef_wdata = sum_n;
      WSEL_DIFF: coef_wdata = diff_n;
      default:   coef_wdata = value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_we) coef_mem[cmd.coef_addr] <= coef_wdata;
    if (cmd.coef_re) coef_rdata <= coef_mem[cmd.coef_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.tw_we) tw_mem[cmd.tw_addr] <= value;
    if (cmd.tw_re) tw_rdata <= tw_mem[cmd.tw_addr];
  end

  // operand select at start and during a reduction
  always_comb begin
    case (cmd.mm_opd)
      OPD_V:   start_x = v;
      OPD_W:   start_x = w;
      default: start_x = u;
    endcase
    case (mm_opd)
      OPD_V:   red_src = v;
      OPD_W:   red_src = w;
      default: red_src = u;
    endcase
  end

  // one bit per step: reduce shifts in x MSB first; multiply doubles then adds
  assign red_r = {acc, red_src[mm_cnt]};
  assign red_n = (red_r >= q_ext) ? VALUE_BITS'(red_r - q_ext) : red_r[VALUE_BITS-1:0];
  assign dbl_r = {acc, 1'b0};
  assign dbl_n = (dbl_r >= q_ext) ? VALUE_BITS'(dbl_r - q_ext) : dbl_r[VALUE_BITS-1:0];
  assign add_r = {1'b0, acc} + {1'b0, v};
  assign add_n = (add_r >= q_ext) ? VALUE_BITS'(add_r - q_ext) : add_r[VALUE_BITS-1:0];

  always_comb begin
    if (mm_op == MM_REDUCE) step_n = red_n;
    else if (!mm_phase)     step_n = dbl_n;
    else if (w[mm_cnt])     step_n = add_n;
    else                    step_n = acc;
  end

  assign mm_last = (mm_cnt == '0) && ((mm_op == MM_REDUCE) || mm_phase);
  assign mm_fin  = mm_busy && mm_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mm_busy <= 1'b0;
      mm_done <= 1'b0;
    end else begin
      mm_done <= 1'b0;
      if (cmd.mm_start) begin
        if (cmd.mm_op == MM_REDUCE && start_x < modulus) mm_done <= 1'b1;
        else mm_busy <= 1'b1;
      end else if (mm_fin) begin
        mm_busy <= 1'b0;
        mm_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mm_start) begin
      mm_op    <= cmd.mm_op;
      mm_opd   <= cmd.mm_opd;
      mm_cnt   <= CNT_BITS'(VALUE_BITS - 1);
      mm_phase <= 1'b0;
      acc      <= '0;
    end else if (mm_busy) begin
      acc <= step_n;
      if (mm_op == MM_MUL && !mm_phase) begin
        mm_phase <= 1'b1;
      end else begin
        mm_phase <= 1'b0;
        if (mm_cnt != '0) mm_cnt <= mm_cnt - CNT_BITS'(1);
      end
    end
    if (cmd.cap_u) u <= coef_rdata;
    if (cmd.cap_v) v <= coef_rdata;
    if (cmd.cap_w) w <= tw_rdata;
    if (mm_fin) begin
      if (mm_op == MM_MUL) begin
        t <= step_n;
      end else begin
        case (mm_opd)
          OPD_V:   v <= step_n;
          OPD_W:   w <= step_n;
          default: u <= step_n;
        endcase
      end
    end
  end

  assign stat.val_ge_q   = (value >= modulus);
  assign stat.mm_done    = mm_done;
  assign stat.log_degree = log_degree;

  `ASSERT_PROP(a_mm_start_idle, clk, rst, cmd.mm_start |-> !mm_busy, "mm start while busy")

endmodule

>>> rtl/ntt_ctrl.sv
// ----------------------------------------------------------------------------
// ntt_ctrl
// Controller: action decode, range checks, butterfly sequencing, result reg.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntt_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        action,
  input  logic [ntt_pkg::IDX_BITS-1:0]      index,
  input  logic [ntt_pkg::STAGE_BITS-1:0]    stage,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ntt_pkg::VALUE_BITS-1:0]    data,
  output logic [1:0]                        status,
  input  logic [ntt_pkg::VALUE_BITS-1:0]    coef_rdata,
  input  ntt_pkg::dp_stat_t                 stat,
  output ntt_pkg::dp_cmd_t                  cmd
);
  import ntt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_RD_U,
    S_RD_V,
    S_CAP_V,
    S_RED_U,
    S_RED_U_W,
    S_RED_V,
    S_RED_V_W,
    S_RED_W,
    S_RED_W_W,
    S_MUL,
    S_MUL_W,
    S_WR_U,
    S_WR_V
  } state_t;

  state_t                  state, state_next;
  logic [TW_AW-1:0]        bfly, bfly_next;
  logic [STAGE_BITS-1:0]   stage_q, stage_q_next;
  logic                    out_valid_next;
  logic [VALUE_BITS-1:0]   data_next;
  logic [1:0]              status_next;

  logic                    accept;
  logic                    coef_oob, tw_oob, run_ok;
  logic [COEF_AW-1:0]      bz, span, mask, idx_u, idx_v, last_b;
  logic [LOG_BITS-1:0]     tw_shift;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign coef_oob = {1'b0, index} >= (IDX_BITS + 1)'(MAX_DEGREE);
  assign tw_oob   = {1'b0, index} >= (IDX_BITS + 1)'(TW_DEPTH);
  assign run_ok   = (stat.log_degree != '0)
                 && ({1'b0, stat.log_degree} <= (LOG_BITS + 1)'(MAX_LOG))
                 && (stage < stat.log_degree);

  // butterfly b: j = b mod m, block base = (b / m) * 2m
  assign bz       = COEF_AW'(bfly);
  assign span     = COEF_AW'(1) << stage_q;
  assign mask     = span - COEF_AW'(1);
  assign idx_u    = ((bz >> stage_q) << (stage_q + STAGE_BITS'(1))) | (bz & mask);
  assign idx_v    = idx_u | span;
  assign tw_shift = stat.log_degree - LOG_BITS'(1) - stage_q;
  assign last_b   = (COEF_AW'(1) << (stat.log_degree - LOG_BITS'(1))) - COEF_AW'(1);

  always_comb begin
    state_next     = state;
    bfly_next      = bfly;
    stage_q_next   = stage_q;
    out_valid_next = out_valid && out_stall;
    data_next      = data;
    status_next    = status;
    cmd            = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action_t'(action))
            ACT_LOAD_COEF: begin
              out_valid_next = 1'b1;
              data_next      = '0;
              if (coef_oob) begin
                status_next = ST_RANGE;
              end else if (stat.val_ge_q) begin
                status_next = ST_VALUE;
              end else begin
                status_next    = ST_OK;
                cmd.coef_we    = 1'b1;
                cmd.coef_addr  = index[COEF_AW-1:0];
                cmd.coef_wsel  = WSEL_VALUE;
              end
            end
            ACT_LOAD_TW: begin
              out_valid_next = 1'b1;
              data_next      = '0;
              if (tw_oob) begin
                status_next = ST_RANGE;
              end else if (stat.val_ge_q) begin
                status_next = ST_VALUE;
              end else begin
                status_next = ST_OK;
                cmd.tw_we   = 1'b1;
                cmd.tw_addr = index[TW_AW-1:0];
              end
            end
            ACT_RUN: begin
              if (run_ok) begin
                stage_q_next = stage;
                bfly_next    = '0;
                state_next   = S_RD_U;
              end else begin
                out_valid_next = 1'b1;
                data_next      = '0;
                status_next    = ST_RANGE;
              end
            end
            default: begin
              if (coef_oob) begin
                out_valid_next = 1'b1;
                data_next      = '0;
                status_next    = ST_RANGE;
              end else begin
                cmd.coef_re   = 1'b1;
                cmd.coef_addr = index[COEF_AW-1:0];
                state_next    = S_READ;
              end
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_next = 1'b1;
        data_next      = coef_rdata;
        status_next    = ST_OK;
        state_next     = S_IDLE;
      end
      S_RD_U: begin
        cmd.coef_re   = 1'b1;
        cmd.coef_addr = idx_u;
        cmd.tw_re     = 1'b1;
        cmd.tw_addr   = TW_AW'((bz & mask) << tw_shift);
        state_next    = S_RD_V;
      end
      S_RD_V: begin
        cmd.coef_re   = 1'b1;
        cmd.coef_addr = idx_v;
        cmd.cap_u     = 1'b1;
        cmd.cap_w     = 1'b1;
        state_next    = S_CAP_V;
      end
      S_CAP_V: begin
        cmd.cap_v  = 1'b1;
        state_next = S_RED_U;
      end
      S_RED_U: begin
        cmd.mm_start = 1'b1;
        cmd.mm_op    = MM_REDUCE;
        cmd.mm_opd   = OPD_U;
        state_next   = S_RED_U_W;
      end
      S_RED_U_W: if (stat.mm_done) state_next = S_RED_V;
      S_RED_V: begin
        cmd.mm_start = 1'b1;
        cmd.mm_op    = MM_REDUCE;
        cmd.mm_opd   = OPD_V;
        state_next   = S_RED_V_W;
      end
      S_RED_V_W: if (stat.mm_done) state_next = S_RED_W;
      S_RED_W: begin
        cmd.mm_start = 1'b1;
        cmd.mm_op    = MM_REDUCE;
        cmd.mm_opd   = OPD_W;
        state_next   = S_RED_W_W;
      end
      S_RED_W_W: if (stat.mm_done) state_next = S_MUL;
      S_MUL: begin
        cmd.mm_start = 1'b1;
        cmd.mm_op    = MM_MUL;
        state_next   = S_MUL_W;
      end
      S_MUL_W: if (stat.mm_done) state_next = S_WR_U;
      S_WR_U: begin
        cmd.coef_we   = 1'b1;
        cmd.coef_addr = idx_u;
        cmd.coef_wsel = WSEL_SUM;
        state_next    = S_WR_V;
      end
      S_WR_V: begin
        cmd.coef_we   = 1'b1;
        cmd.coef_addr = idx_v;
        cmd.coef_wsel = WSEL_DIFF;
        if (bz == last_b) begin
          out_valid_next = 1'b1;
          data_next      = '0;
          status_next    = ST_OK;
          state_next     = S_IDLE;
        end else begin
          bfly_next  = bfly + TW_AW'(1);
          state_next = S_RD_U;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    bfly    <= bfly_next;
    stage_q <= stage_q_next;
    data    <= data_next;
    status  <= status_next;
  end

  `ASSERT_PROP(a_accept_idle, clk, rst, accept |-> (state == S_IDLE), "accept outside idle")
  `ASSERT_NEVER(a_rw_same, clk, rst, cmd.coef_we && cmd.coef_re, "coef read and write together")
  `ASSERT_PROP(a_done_wait, clk, rst, stat.mm_done |-> (state == S_RED_U_W || state == S_RED_V_W || state == S_RED_W_W || state == S_MUL_W), "mm done outside wait")

endmodule

>>> rtl/ntt_butterfly_stage.sv
// ----------------------------------------------------------------------------
// ntt_butterfly_stage
// Radix-2 NTT stage over an in-place coefficient store, exact modular
// twiddle products, controller plus datapath.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   action, index, value, stage
//  out      source     out_valid / out_stall data, status
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
//  A load is answered from idle, a read after its S_READ state; one
//  transaction in, one out. A run does n/2 butterflies, its time set by the
//  bit-serial multiply over 62 bits; an operand not below q adds a
//  bit-serial reduction before the multiply.
//  Reset clears control and config state; stores are undefined until written.
//  in_stall is high while an item is in work or a result is held stalled.
// ----------------------------------------------------------------------------
module ntt_butterfly_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        action,
  input  logic [ntt_pkg::IDX_BITS-1:0]      index,
  input  logic [ntt_pkg::VALUE_BITS-1:0]    value,
  input  logic [ntt_pkg::STAGE_BITS-1:0]    stage,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ntt_pkg::VALUE_BITS-1:0]    data,
  output logic [1:0]                        status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [ntt_pkg::VALUE_BITS-1:0]    cfg_data
);
  import ntt_pkg::*;

  dp_cmd_t               cmd;
  dp_stat_t              stat;
  logic [VALUE_BITS-1:0] coef_rdata;

  // user sends config writes only while idle (not enforced); always take them
  assign cfg_ready = 1'b1;

  ntt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .index      (index),
    .stage      (stage),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data       (data),
    .status     (status),
    .coef_rdata (coef_rdata),
    .stat       (stat),
    .cmd        (cmd)
  );

  ntt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .coef_rdata (coef_rdata)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ntt_butterfly_stage: directed table, then random
// loads, reads and stage runs, each result checked against a local predictor.
// ----------------------------------------------------------------------------
module testbench;
  import ntt_pkg::*;

  // config indexes the block does not decode
  localparam logic [1:0] REG_SPARE2 = 2'd2;
  localparam logic [1:0] REG_SPARE3 = 2'd3;
  localparam logic [61:0] Q_MAX = 62'h3FFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = ACT_READ;
  logic [11:0] index = '0;
  logic [61:0] value = '0;
  logic [3:0] stage = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [61:0] data;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [61:0] cfg_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ntt_butterfly_stage dut (.*);

  // Predictor state: stores, written flags and the two registers
  logic [61:0] coef_mem [MAX_DEGREE];
  logic [61:0] tw_mem [TW_DEPTH];
  bit coef_written [MAX_DEGREE];
  logic [61:0] cur_q = MOD_RESET;
  logic [3:0] cur_log = LOG_RESET;

  // expected results, oldest first
  logic [61:0] want_data [$];
  logic [1:0] want_status [$];

  int errors = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  bit hold_req = 0;
  int hold_left = 0;
  bit offering = 0;

  function automatic logic [61:0] mulmod(logic [61:0] a, logic [61:0] b);
    logic [127:0] p;
    p = {66'b0, a} * {66'b0, b};
    return 62'(p % {66'b0, cur_q});
  endfunction

  // One transaction through the predictor: updates state, yields result.
  task automatic ntt_predict(action_t act, logic [11:0] idx, logic [61:0] val,
                             logic [3:0] stg, output logic [61:0] rd,
                             output logic [1:0] rs);
    int n, m, stp, k, j;
    logic [61:0] u, v, w, t;
    logic [63:0] sum;
    rd = '0;
    rs = ST_OK;
    case (act)
      ACT_LOAD_COEF: begin
        if (val >= cur_q) rs = ST_VALUE;
        else begin
          coef_mem[idx] = val;
          coef_written[idx] = 1;
        end
      end
      ACT_LOAD_TW: begin
        if (idx >= TW_DEPTH) rs = ST_RANGE;
        else if (val >= cur_q) rs = ST_VALUE;
        else tw_mem[idx] = val;
      end
      ACT_RUN: begin
        if (cur_log == 0 || cur_log > MAX_LOG || stg >= cur_log) rs = ST_RANGE;
        else begin
          n = 1 << cur_log;
          m = 1 << stg;
          stp = n / (2 * m);
          for (k = 0; k < n; k += 2 * m) begin
            for (j = 0; j < m; j++) begin
              // stale entries are reduced before use
              w = tw_mem[(stp * j) % TW_DEPTH] % cur_q;
              u = coef_mem[k + j] % cur_q;
              v = coef_mem[k + j + m] % cur_q;
              t = mulmod(v, w);
              sum = {2'b0, u} + {2'b0, t};
              coef_mem[k + j] = 62'(sum % {2'b0, cur_q});
              sum = {2'b0, u} + {2'b0, cur_q} - {2'b0, t};
              coef_mem[k + j + m] = 62'(sum % {2'b0, cur_q});
            end
          end
        end
      end
      default: rd = coef_mem[idx];
    endcase
  endtask

  function automatic logic [61:0] rand62();
    return 62'({$urandom, $urandom} & {2'b0, Q_MAX});
  endfunction

  task automatic drop_valid();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 0;
    end
  endtask

  // Offer one transaction, hold it until accepted, queue its expectation.
  task automatic send_item(action_t act, logic [11:0] idx, logic [61:0] val,
                           logic [3:0] stg, bit typed = 0,
                           logic [61:0] ed = '0, logic [1:0] es = ST_OK);
    logic [61:0] pd;
    logic [1:0] ps;
    in_valid <= 1'b1;
    action <= act;
    index <= idx;
    value <= val;
    stage <= stg;
    offering = 1;
    do @(posedge clk); while (in_stall);
    ntt_predict(act, idx, val, stg, pd, ps);
    if (typed) begin
      pd = ed;
      ps = es;
    end
    want_data.push_back(pd);
    want_status.push_back(ps);
    if ($urandom_range(99) < snd_idle) begin
      drop_valid();
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    drop_valid();
    while (want_data.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write, only with the block idle.
  task automatic cfg_write(logic [1:0] ri, logic [61:0] wd);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= wd;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (ri == REG_MODULUS && wd >= 2) cur_q = wd;
    else if (ri == REG_LOG_DEGREE) cur_log = wd[3:0];
    @(posedge clk);
  endtask

  // Result side: check each transaction, then pick the next stall value.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (want_data.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result data=%h status=%0d", data, status);
        end else begin
          if (data !== want_data[0] || status !== want_status[0]) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: data exp %h got %h, status exp %0d got %0d",
                       want_data[0], data, want_status[0], status);
          end
          void'(want_data.pop_front());
          void'(want_status.pop_front());
        end
      end
      if (hold_req) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle);
      end
    end
  end

  // Directed table: a row is either a register write or one transaction.
  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    action_t     act;
    logic [11:0] idx;
    logic [61:0] val;
    logic [3:0]  stg;
    bit          typed;
    logic [61:0] ed;
    logic [1:0]  es;
  } row_t;

  row_t rows [$];

  function automatic void add_row(bit c, logic [1:0] ri, action_t a, logic [11:0] i,
                                  logic [61:0] v, logic [3:0] s, bit ty,
                                  logic [61:0] ed, logic [1:0] es);
    row_t r;
    r.is_cfg = c; r.reg_idx = ri; r.act = a; r.idx = i; r.val = v; r.stg = s;
    r.typed = ty; r.ed = ed; r.es = es;
    rows.push_back(r);
  endfunction

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [61:0] qset [3];
    logic [3:0] lset [3];
    int sidle [3];
    int ridle [3];
    int n, sel, p, it;
    logic [11:0] ri;
    logic [61:0] rv;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: q = 12289, n = 4096
    add_row(0, 0, ACT_LOAD_COEF, 12'd0, 62'd0, 0, 1, 0, ST_OK);
    add_row(0, 0, ACT_LOAD_COEF, 12'd4095, 62'd12288, 0, 1, 0, ST_OK);
    add_row(0, 0, ACT_LOAD_COEF, 12'd1, 62'd12289, 0, 1, 0, ST_VALUE);
    add_row(0, 0, ACT_LOAD_COEF, 12'd2, Q_MAX, 0, 1, 0, ST_VALUE);
    add_row(0, 0, ACT_LOAD_TW, 12'd2047, 62'd5, 0, 1, 0, ST_OK);
    // index check wins over value check
    add_row(0, 0, ACT_LOAD_TW, 12'd4095, Q_MAX, 0, 1, 0, ST_RANGE);
    add_row(0, 0, ACT_READ, 12'd4095, 0, 0, 1, 62'd12288, ST_OK);
    add_row(0, 0, ACT_READ, 12'd0, Q_MAX, 4'hF, 1, 0, ST_OK);
    add_row(0, 0, ACT_RUN, 0, 0, 4'd12, 1, 0, ST_RANGE);
    add_row(0, 0, ACT_RUN, 12'hFFF, Q_MAX, 4'd15, 1, 0, ST_RANGE);
    // bad degrees
    add_row(1, REG_LOG_DEGREE, ACT_RUN, 0, 62'd0, 0, 0, 0, 0);
    add_row(0, 0, ACT_RUN, 0, 0, 4'd0, 1, 0, ST_RANGE);
    add_row(1, REG_LOG_DEGREE, ACT_RUN, 0, 62'd15, 0, 0, 0, 0);
    add_row(0, 0, ACT_RUN, 0, 0, 4'd0, 1, 0, ST_RANGE);
    add_row(1, REG_LOG_DEGREE, ACT_RUN, 0, 62'd13, 0, 0, 0, 0);
    add_row(0, 0, ACT_RUN, 0, 0, 4'd1, 1, 0, ST_RANGE);
    // small transform, then stale operands after lowering q
    add_row(1, REG_MODULUS, ACT_RUN, 0, 62'd17, 0, 0, 0, 0);
    add_row(1, REG_LOG_DEGREE, ACT_RUN, 0, 62'd1, 0, 0, 0, 0);
    add_row(0, 0, ACT_LOAD_COEF, 12'd0, 62'd16, 0, 1, 0, ST_OK);
    add_row(0, 0, ACT_LOAD_COEF, 12'd1, 62'd9, 0, 1, 0, ST_OK);
    add_row(0, 0, ACT_LOAD_TW, 12'd0, 62'd3, 0, 1, 0, ST_OK);
    add_row(0, 0, ACT_RUN, 0, 0, 4'd0, 0, 0, 0);
    add_row(0, 0, ACT_READ, 12'd1, 0, 0, 0, 0, 0);
    add_row(0, 0, ACT_LOAD_COEF, 12'd1, 62'd16, 0, 1, 0, ST_OK);
    add_row(1, REG_MODULUS, ACT_RUN, 0, 62'd7, 0, 0, 0, 0);
    add_row(0, 0, ACT_READ, 12'd1, 0, 0, 1, 62'd16, ST_OK);
    // ignored writes: modulus below 2, undecoded indexes
    add_row(1, REG_MODULUS, ACT_RUN, 0, 62'd1, 0, 0, 0, 0);
    add_row(1, REG_SPARE2, ACT_RUN, 0, 62'd3, 0, 0, 0, 0);
    add_row(1, REG_SPARE3, ACT_RUN, 0, Q_MAX, 0, 0, 0, 0);
    add_row(0, 0, ACT_RUN, 0, 0, 4'd0, 0, 0, 0);
    add_row(0, 0, ACT_READ, 12'd0, 0, 0, 0, 0, 0);
    add_row(0, 0, ACT_READ, 12'd1, 0, 0, 0, 0, 0);

    snd_idle = 26;
    rcv_idle = 49;
    foreach (rows[r]) begin
      if (rows[r].is_cfg) cfg_write(rows[r].reg_idx, rows[r].val);
      else send_item(rows[r].act, rows[r].idx, rows[r].val, rows[r].stg,
                     rows[r].typed, rows[r].ed, rows[r].es);
    end

    // random phases: largest modulus, a mid prime, smallest modulus
    qset = '{Q_MAX, 62'd998244353, 62'd2};
    lset = '{4'd3, 4'd4, 4'd2};
    sidle = '{26, 49, 0};
    ridle = '{49, 26, 0};
    for (p = 0; p < 3; p++) begin
      cfg_write(REG_MODULUS, qset[p]);
      cfg_write(REG_LOG_DEGREE, lset[p]);
      snd_idle = sidle[p];
      rcv_idle = ridle[p];
      n = 1 << lset[p];
      // well-formed preload so that every run touches written entries
      for (it = 0; it < n; it++) send_item(ACT_LOAD_COEF, 12'(it), rand62() % cur_q, 4'd0);
      for (it = 0; it < n / 2; it++) send_item(ACT_LOAD_TW, 12'(it), rand62() % cur_q, 4'd0);
      for (it = 0; it < 75; it++) begin
        if (p == 0 && it == 20) hold_req = 1;  // long receiver hold-off
        if (p == 1 && it == 30) begin
          drop_valid();
          while (want_data.size() != 0) @(posedge clk);
        end
        sel = $urandom_range(99);
        rv = ($urandom_range(9) < 6) ? rand62() % cur_q : rand62();
        if (sel < 35) begin
          ri = ($urandom_range(9) < 7) ? 12'($urandom_range(0, n - 1)) : 12'($urandom);
          send_item(ACT_LOAD_COEF, ri, rv, 4'($urandom));
        end else if (sel < 50) begin
          ri = ($urandom_range(9) < 7) ? 12'($urandom_range(0, n / 2 - 1)) : 12'($urandom);
          send_item(ACT_LOAD_TW, ri, rv, 4'($urandom));
        end else if (sel < 78) begin
          send_item(ACT_RUN, 12'($urandom), rv,
                    ($urandom_range(9) < 8) ? 4'($urandom_range(0, lset[p] + 1))
                                            : 4'($urandom));
        end else begin
          ri = 12'($urandom);
          if (!coef_written[ri]) ri = 12'($urandom_range(0, n - 1));
          send_item(ACT_READ, ri, rv, 4'($urandom));
        end
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && want_data.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/ntt_pkg.sv
rtl/ntt_dp.sv
rtl/ntt_ctrl.sv
rtl/ntt_butterfly_stage.sv
dv/testbench.sv
